@@ hdl/dlb_pkg.sv @@
// Shared constants, types and state codes for the discrete log block.
package dlb_pkg;

    localparam int VALUE_W     = 24;
    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int TSIZE_W     = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int ENTRY_W     = VALUE_W + ADDR_W;

    localparam logic [CFG_IDX_W-1:0] REG_BASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TSIZE   = 2'd2;

    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_NO_INV    = 2'd2;

    typedef struct packed {
        logic [VALUE_W-1:0] val;
        logic [ADDR_W-1:0]  idx;
    } t_entry;

    typedef enum logic [4:0] {
        S_IDLE, S_BINIT, S_BRED, S_FILL, S_FILLW,
        S_IDIV, S_IDIVW, S_IMULW,
        S_SSEG, S_SRI, S_SRJ, S_SCMP,
        S_QCHK, S_QRED, S_QBS, S_QBSW, S_QEQ, S_QNEXT, S_QMULW, S_QOUT
    } t_state;

endpackage

@@ hdl/dlb_ram.sv @@
// Simple dual-port RAM with registered read data.
module dlb_ram #(
    parameter int W  = 36,
    parameter int AW = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ hdl/dlb_mulmod.sv @@
// Bit-serial modular multiplier: a * b mod n, one bit of b per cycle, a < n.
module dlb_mulmod
    import dlb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [VALUE_W-1:0] i_a,
    input  logic [VALUE_W-1:0] i_b,
    input  logic [VALUE_W-1:0] i_n,
    output logic               o_done,
    output logic [VALUE_W-1:0] o_res
);
    localparam int CW = $clog2(VALUE_W);

    logic               r_busy;
    logic               r_done;
    logic [CW-1:0]      r_cnt;
    logic [VALUE_W-1:0] r_acc, r_a, r_b, r_n;
    logic [VALUE_W:0]   dbl, dbl_red, sum, sum_red;

    always_comb begin
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= {1'b0, r_n}) ? dbl - {1'b0, r_n} : dbl;
        sum     = dbl_red + (r_b[VALUE_W-1] ? {1'b0, r_a} : '0);
        sum_red = (sum >= {1'b0, r_n}) ? sum - {1'b0, r_n} : sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(VALUE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
            r_n   <= i_n;
        end else if (r_busy) begin
            r_acc <= sum_red[VALUE_W-1:0];
            r_b   <= {r_b[VALUE_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_res  = r_acc;
endmodule

@@ hdl/dlb_divider.sv @@
// Restoring divider, one quotient bit per cycle.
module dlb_divider
    import dlb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [VALUE_W-1:0] i_dividend,
    input  logic [VALUE_W-1:0] i_divisor,
    output logic               o_done,
    output logic [VALUE_W-1:0] o_quot,
    output logic [VALUE_W-1:0] o_rem
);
    localparam int CW = $clog2(VALUE_W);

    logic               r_busy;
    logic               r_done;
    logic [CW-1:0]      r_cnt;
    logic [VALUE_W-1:0] r_q, r_d, r_rem;
    logic [VALUE_W:0]   trial;

    assign trial = {r_rem, r_q[VALUE_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(VALUE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // r_q shifts the dividend out at the top and the quotient in at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_d   <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_d}) begin
                r_rem <= VALUE_W'(trial - {1'b0, r_d});
                r_q   <= {r_q[VALUE_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[VALUE_W-1:0];
                r_q   <= {r_q[VALUE_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;
endmodule

@@ hdl/discrete_log_bsgs.sv @@
// Baby-step giant-step discrete logarithm: top level with table build and search sequencer.
//
// The first query after reset or after any write to the base, modulus or table-size
// register first builds the table: m baby steps, each a bit-serial modular multiply,
// an extended Euclid inverse of base^m (a divide and a multiply per step), and a merge
// sort over two table memories for ceil(log2 m) passes. A query then reduces the target
// with a multiply plus, per giant step, up to (log2 m + 2) memory reads and a multiply;
// the worst case is m giant steps. The result strobe o_valid is high for a single cycle
// and must be taken then; busy stays high meanwhile.
module discrete_log_bsgs
    import dlb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [VALUE_W-1:0]   i_target,
    output logic                 o_valid,
    output logic [VALUE_W-1:0]   o_log_value,
    output logic [1:0]           o_status,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [VALUE_W-1:0]   i_cfg_data
);
    t_state r_state, n_state;

    logic [VALUE_W-1:0] r_base, n_base, r_mod, n_mod, r_giant, n_giant;
    logic [TSIZE_W-1:0] r_tsize, n_tsize;
    logic               r_ready, n_ready, r_sel, n_sel;
    logic [CNT_W-1:0]   r_m, n_m, r_k, n_k, r_w, n_w, r_lo, n_lo, r_hi, n_hi;
    logic [CNT_W-1:0]   r_mid, n_mid, r_i, n_i, r_j, n_j, r_o, n_o, r_gi, n_gi;
    logic [VALUE_W-1:0] r_a, n_a, r_ak, n_ak, r_c, n_c, r_target, n_target;
    logic [VALUE_W-1:0] r_r0, n_r0, r_r1, n_r1, r_t0, n_t0, r_t1, n_t1;
    logic [VALUE_W-1:0] r_log, n_log;
    logic [1:0]         r_status, n_status;
    t_entry             r_hv, n_hv;

    logic               mul_start, mul_done, div_start, div_done;
    logic [VALUE_W-1:0] mul_a, mul_b, mul_res, div_quot, div_rem;
    logic               we_a, we_b, fill_we, merge_we;
    logic [ADDR_W-1:0]  waddr, raddr;
    t_entry             wdata, rd_a, rd_b, rdata;

    logic [CNT_W-1:0]   m_eff, seg_mid, seg_hi, lo_next, w_next, bs_mid;
    logic [CNT_W:0]     bs_sum;
    logic [VALUE_W:0]   t_diff;
    logic [2*CNT_W-1:0] prod;
    logic               take_j;
    logic               cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && (i_cfg_index == REG_BASE
                                         || i_cfg_index == REG_MODULUS
                                         || i_cfg_index == REG_TSIZE);

    always_comb begin
        if (r_tsize == '0) begin
            m_eff = CNT_W'(1);
        end else if (r_tsize > TSIZE_W'(TABLE_DEPTH)) begin
            m_eff = CNT_W'(TABLE_DEPTH);
        end else begin
            m_eff = CNT_W'(r_tsize);
        end
    end

    dlb_mulmod u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_n     (r_mod),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    dlb_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_r0),
        .i_divisor  (r_r1),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    dlb_ram #(.W(ENTRY_W), .AW(ADDR_W)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_a)
    );

    dlb_ram #(.W(ENTRY_W), .AW(ADDR_W)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_b)
    );

    assign rdata = r_sel ? rd_b : rd_a;
    assign we_a  = fill_we || (merge_we && r_sel);
    assign we_b  = merge_we && !r_sel;

    always_comb begin
        seg_mid = (r_lo + r_w < r_m) ? r_lo + r_w : r_m;
        seg_hi  = (r_lo + (r_w << 1) < r_m) ? r_lo + (r_w << 1) : r_m;
        lo_next = r_lo + (r_w << 1);
        w_next  = r_w << 1;
        bs_sum  = {1'b0, r_lo} + {1'b0, r_hi};
        bs_mid  = bs_sum[CNT_W:1];
        // merge takes the right head when the left run is used up or when strictly smaller: keeps k order
        take_j  = (r_i >= r_mid) || (r_j < r_hi && rdata.val < r_hv.val);
        t_diff  = (r_t0 >= mul_res) ? {1'b0, r_t0 - mul_res}
                                    : {1'b0, r_t0} + {1'b0, r_mod} - {1'b0, mul_res};
        prod    = r_gi * r_m;
    end

    always_comb begin
        n_state  = r_state;
        n_base   = r_base;
        n_mod    = r_mod;
        n_tsize  = r_tsize;
        n_ready  = r_ready;
        n_giant  = r_giant;
        n_sel    = r_sel;
        n_m      = r_m;
        n_k      = r_k;
        n_w      = r_w;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_i      = r_i;
        n_j      = r_j;
        n_o      = r_o;
        n_gi     = r_gi;
        n_a      = r_a;
        n_ak     = r_ak;
        n_c      = r_c;
        n_target = r_target;
        n_r0     = r_r0;
        n_r1     = r_r1;
        n_t0     = r_t0;
        n_t1     = r_t1;
        n_log    = r_log;
        n_status = r_status;
        n_hv     = r_hv;
        mul_start = 1'b0;
        mul_a     = r_c;
        mul_b     = r_giant;
        div_start = 1'b0;
        fill_we   = 1'b0;
        merge_we  = 1'b0;
        waddr     = r_o[ADDR_W-1:0];
        wdata     = take_j ? rdata : r_hv;
        raddr     = r_i[ADDR_W-1:0];
        busy      = (r_state != S_IDLE);
        o_valid   = 1'b0;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BASE:    n_base  = i_cfg_data;
                REG_MODULUS: n_mod   = i_cfg_data;
                REG_TSIZE:   n_tsize = i_cfg_data[TSIZE_W-1:0];
                default:     ;
            endcase
            if (cfg_wr) begin
                n_ready = 1'b0;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_target = i_target;
                    n_state  = r_ready ? S_QCHK : S_BINIT;
                end
            end
            S_BINIT: begin
                n_m     = m_eff;
                n_ready = 1'b1;
                n_giant = '0;
                n_sel   = 1'b0;
                if (r_mod < VALUE_W'(2)) begin
                    n_state = S_QCHK;
                end else begin
                    mul_start = 1'b1;
                    mul_a     = VALUE_W'(1);
                    mul_b     = r_base;
                    n_state   = S_BRED;
                end
            end
            S_BRED: begin
                if (mul_done) begin
                    n_a     = mul_res;
                    n_ak    = VALUE_W'(1);
                    n_k     = '0;
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                fill_we   = 1'b1;
                waddr     = r_k[ADDR_W-1:0];
                wdata     = '{val: r_ak, idx: r_k[ADDR_W-1:0]};
                mul_start = 1'b1;
                mul_a     = r_ak;
                mul_b     = r_a;
                n_state   = S_FILLW;
            end
            S_FILLW: begin
                if (mul_done) begin
                    n_ak = mul_res;
                    n_k  = r_k + 1'b1;
                    if (r_k + 1'b1 == r_m) begin
                        n_r0    = r_mod;
                        n_r1    = mul_res;
                        n_t0    = '0;
                        n_t1    = VALUE_W'(1);
                        n_state = S_IDIV;
                    end else begin
                        n_state = S_FILL;
                    end
                end
            end
            S_IDIV: begin
                if (r_r1 == '0) begin
                    // zero marks a step factor with no inverse
                    n_giant = (r_r0 == VALUE_W'(1)) ? r_t0 : '0;
                    n_w     = CNT_W'(1);
                    n_lo    = '0;
                    n_state = (r_m > CNT_W'(1)) ? S_SSEG : S_QCHK;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_IDIVW;
                end
            end
            S_IDIVW: begin
                if (div_done) begin
                    mul_start = 1'b1;
                    mul_a     = r_t1;
                    mul_b     = div_quot;
                    n_state   = S_IMULW;
                end
            end
            S_IMULW: begin
                if (mul_done) begin
                    n_r0    = r_r1;
                    n_r1    = div_rem;
                    n_t0    = r_t1;
                    n_t1    = t_diff[VALUE_W-1:0];
                    n_state = S_IDIV;
                end
            end
            S_SSEG: begin
                n_mid   = seg_mid;
                n_hi    = seg_hi;
                n_i     = r_lo;
                n_j     = seg_mid;
                n_o     = r_lo;
                n_state = S_SRI;
            end
            S_SRI: begin
                raddr   = r_i[ADDR_W-1:0];
                n_state = S_SRJ;
            end
            S_SRJ: begin
                n_hv    = rdata;
                raddr   = r_j[ADDR_W-1:0];
                n_state = S_SCMP;
            end
            S_SCMP: begin
                merge_we = 1'b1;
                n_o      = r_o + 1'b1;
                if (take_j) begin
                    n_j = r_j + 1'b1;
                end else begin
                    n_i = r_i + 1'b1;
                end
                if (r_o + 1'b1 == r_hi) begin
                    if (lo_next >= r_m) begin
                        n_sel = !r_sel;
                        n_w   = w_next;
                        n_lo  = '0;
                        n_state = (w_next >= r_m) ? S_QCHK : S_SSEG;
                    end else begin
                        n_lo    = lo_next;
                        n_state = S_SSEG;
                    end
                end else begin
                    n_state = S_SRI;
                end
            end
            S_QCHK: begin
                if (r_mod < VALUE_W'(2) || r_giant == '0) begin
                    n_log    = '0;
                    n_status = ST_NO_INV;
                    n_state  = S_QOUT;
                end else begin
                    mul_start = 1'b1;
                    mul_a     = VALUE_W'(1);
                    mul_b     = r_target;
                    n_state   = S_QRED;
                end
            end
            S_QRED: begin
                if (mul_done) begin
                    n_c     = mul_res;
                    n_gi    = '0;
                    n_lo    = '0;
                    n_hi    = r_m;
                    n_state = S_QBS;
                end
            end
            S_QBS: begin
                if (r_lo < r_hi) begin
                    raddr   = bs_mid[ADDR_W-1:0];
                    n_mid   = bs_mid;
                    n_state = S_QBSW;
                end else if (r_lo < r_m) begin
                    raddr   = r_lo[ADDR_W-1:0];
                    n_state = S_QEQ;
                end else begin
                    n_state = S_QNEXT;
                end
            end
            S_QBSW: begin
                if (rdata.val < r_c) begin
                    n_lo = r_mid + 1'b1;
                end else begin
                    n_hi = r_mid;
                end
                n_state = S_QBS;
            end
            S_QEQ: begin
                if (rdata.val == r_c) begin
                    n_log    = VALUE_W'(prod) + VALUE_W'(rdata.idx);
                    n_status = ST_FOUND;
                    n_state  = S_QOUT;
                end else begin
                    n_state = S_QNEXT;
                end
            end
            S_QNEXT: begin
                mul_start = 1'b1;
                mul_a     = r_c;
                mul_b     = r_giant;
                n_state   = S_QMULW;
            end
            S_QMULW: begin
                if (mul_done) begin
                    n_c  = mul_res;
                    n_gi = r_gi + 1'b1;
                    if (r_gi + 1'b1 == r_m) begin
                        n_log    = '0;
                        n_status = ST_NOT_FOUND;
                        n_state  = S_QOUT;
                    end else begin
                        n_lo    = '0;
                        n_hi    = r_m;
                        n_state = S_QBS;
                    end
                end
            end
            S_QOUT: begin
                o_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_base  <= VALUE_W'(1);
            r_mod   <= VALUE_W'(3);
            r_tsize <= TSIZE_W'(TABLE_DEPTH);
            r_ready <= 1'b0;
            r_giant <= '0;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_base  <= n_base;
            r_mod   <= n_mod;
            r_tsize <= n_tsize;
            r_ready <= n_ready;
            r_giant <= n_giant;
            r_sel   <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m      <= n_m;
        r_k      <= n_k;
        r_w      <= n_w;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_i      <= n_i;
        r_j      <= n_j;
        r_o      <= n_o;
        r_gi     <= n_gi;
        r_a      <= n_a;
        r_ak     <= n_ak;
        r_c      <= n_c;
        r_target <= n_target;
        r_r0     <= n_r0;
        r_r1     <= n_r1;
        r_t0     <= n_t0;
        r_t1     <= n_t1;
        r_log    <= n_log;
        r_status <= n_status;
        r_hv     <= n_hv;
    end

    assign o_log_value = r_log;
    assign o_status    = r_status;

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid && !busy)
        else $error("result strobe longer than one cycle");

    a_zero_unless_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_FOUND) |-> (o_log_value == '0))
        else $error("log value nonzero on a failed search");

    a_cfg_clears_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && r_state == S_IDLE) |=> !r_ready)
        else $error("configuration transfer did not invalidate the table");

    a_search_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QBS) |-> (r_lo <= r_hi && r_hi <= r_m && r_gi < r_m))
        else $error("search window out of table range");
endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the baby-step giant-step discrete log block.
module tb_top
    import dlb_pkg::*;
();

    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE_CYC  = 8;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {J_QUERY, J_CFG, J_DRAIN} t_job_kind;

    typedef struct {
        t_job_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [VALUE_W-1:0]   data;
        bit                   no_gap;
    } t_job;

    typedef struct {
        logic [VALUE_W-1:0] log_value;
        logic [1:0]         status;
    } t_answer;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [VALUE_W-1:0]   i_target = '0;
    logic                 o_valid;
    logic [VALUE_W-1:0]   o_log_value;
    logic [1:0]           o_status;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [VALUE_W-1:0]   i_cfg_data = '0;

    t_job    job_q[$];
    t_answer answer_q[$];
    int      n_errors = 0;
    int      cycle_cnt = 0;
    int      quiet_cnt = 0;

    // predictor copy of configuration and derived table
    longint unsigned p_base = 1;
    longint unsigned p_mod = 3;
    longint unsigned p_tsize = 4096;
    bit              p_built = 1'b0;
    longint unsigned p_giant = 0;
    int              p_m = 0;
    int              step_of[longint unsigned];

    discrete_log_bsgs u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_target    (i_target),
        .o_valid     (o_valid),
        .o_log_value (o_log_value),
        .o_status    (o_status),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint unsigned mul_mod(longint unsigned x, longint unsigned y,
                                                longint unsigned n);
        return (x * y) % n;
    endfunction

    function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e,
                                                longint unsigned n);
        longint unsigned r;
        longint unsigned x;
        r = 1 % n;
        x = b % n;
        while (e != 0) begin
            if (e[0]) r = mul_mod(r, x, n);
            x = mul_mod(x, x, n);
            e = e >> 1;
        end
        return r;
    endfunction

    // zero when x has no inverse mod n
    function automatic longint unsigned inv_mod(longint unsigned x, longint unsigned n);
        longint r0, r1, t0, t1, q, tmp;
        r0 = n; r1 = x; t0 = 0; t1 = 1;
        while (r1 != 0) begin
            q = r0 / r1;
            tmp = r0 - q * r1; r0 = r1; r1 = tmp;
            tmp = t0 - q * t1; t0 = t1; t1 = tmp;
        end
        if (r0 != 1) return 0;
        if (t0 < 0) t0 = t0 + longint'(n);
        return longint'(t0) % longint'(n);
    endfunction

    function automatic void build_baby_steps();
        longint unsigned a, ak;
        p_m = (p_tsize == 0) ? 1 : (p_tsize > TABLE_DEPTH ? TABLE_DEPTH : int'(p_tsize));
        p_built = 1'b1;
        p_giant = 0;
        step_of.delete();
        if (p_mod < 2) return;
        a = p_base % p_mod;
        ak = 1;
        for (int k = 0; k < p_m; k++) begin
            // keep the smallest step for repeated values
            if (!step_of.exists(ak)) step_of[ak] = k;
            ak = mul_mod(ak, a, p_mod);
        end
        p_giant = inv_mod(ak, p_mod);
    endfunction

    function automatic t_answer solve_log(logic [VALUE_W-1:0] tgt);
        t_answer         ans;
        longint unsigned c;
        longint unsigned e;
        if (!p_built) build_baby_steps();
        ans.log_value = '0;
        ans.status = ST_NO_INV;
        if (p_mod < 2 || p_giant == 0) return ans;
        c = longint'(tgt) % p_mod;
        for (int i = 0; i < p_m; i++) begin
            if (step_of.exists(c)) begin
                e = longint'(i) * p_m + step_of[c];
                ans.log_value = e[VALUE_W-1:0];
                ans.status = ST_FOUND;
                return ans;
            end
            c = mul_mod(c, p_giant, p_mod);
        end
        ans.status = ST_NOT_FOUND;
        return ans;
    endfunction

    function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                            logic [VALUE_W-1:0] data);
        case (idx)
            REG_BASE:    begin p_base = data; p_built = 1'b0; end
            REG_MODULUS: begin p_mod = data; p_built = 1'b0; end
            REG_TSIZE:   begin p_tsize = data[TSIZE_W-1:0]; p_built = 1'b0; end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_cnt);
        n_errors++;
    endtask

    // stimulus builders
    task automatic add_query(logic [VALUE_W-1:0] tgt, bit no_gap = 1'b0);
        job_q.push_back('{J_QUERY, '0, tgt, no_gap});
    endtask

    task automatic add_reg(logic [CFG_IDX_W-1:0] idx, logic [VALUE_W-1:0] data);
        job_q.push_back('{J_CFG, idx, data, 1'b0});
    endtask

    task automatic add_drain();
        job_q.push_back('{J_DRAIN, '0, '0, 1'b0});
    endtask

    task automatic add_setting(logic [VALUE_W-1:0] b, logic [VALUE_W-1:0] n,
                               logic [VALUE_W-1:0] m);
        add_reg(REG_BASE, b);
        add_reg(REG_MODULUS, n);
        add_reg(REG_TSIZE, m);
    endtask

    // driver: queries, register writes and drain pauses in job order
    always @(posedge i_clk) begin
        bit   keep_start;
        bit   keep_cfg;
        t_job head;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_valid <= 1'b0;
            quiet_cnt <= 0;
        end else begin
            keep_start = start && busy;
            keep_cfg = i_cfg_valid && !o_cfg_ready;
            if (start && !busy) answer_q.push_back(solve_log(i_target));
            if (i_cfg_valid && o_cfg_ready) apply_reg_write(i_cfg_index, i_cfg_data);
            if (answer_q.size() == 0 && !busy && !start)
                quiet_cnt <= quiet_cnt + 1;
            else
                quiet_cnt <= 0;
            if (!keep_start && !keep_cfg && job_q.size() > 0) begin
                head = job_q[0];
                case (head.kind)
                    J_QUERY: begin
                        if (head.no_gap || $urandom_range(99) >= 26) begin
                            keep_start = 1'b1;
                            i_target <= head.data;
                            void'(job_q.pop_front());
                        end
                    end
                    J_CFG: begin
                        // only while idle and settled
                        if (!(start && !busy) && quiet_cnt >= SETTLE_CYC
                            && $urandom_range(99) >= 26) begin
                            keep_cfg = 1'b1;
                            i_cfg_index <= head.idx;
                            i_cfg_data <= head.data;
                            void'(job_q.pop_front());
                        end
                    end
                    default: begin
                        if (answer_q.size() == 0 && !(start && !busy))
                            void'(job_q.pop_front());
                    end
                endcase
            end
            start <= keep_start;
            i_cfg_valid <= keep_cfg;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid) begin
            if (answer_q.size() == 0) begin
                $display("unexpected result at cycle %0d", cycle_cnt);
                n_errors++;
            end else begin
                want = answer_q.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_log_value !== want.log_value)
                    report_mismatch("log_value", o_log_value, want.log_value);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("[discrete_log_bsgs] ERROR");
            $finish;
        end
    end

    initial begin
        longint unsigned n, b, m;
        // basic prime modulus
        add_setting(24'd2, 24'd101, 24'd11);
        add_query(24'd0); add_query(24'd1); add_query(24'd2); add_query(24'd100);
        add_query(24'hFFFFFF); add_query(24'd101); add_query(24'd64); add_query(24'h800000);
        // base reduces to zero: giant factor not invertible
        add_setting(24'hFFFFFF, 24'hFFFFFF, 24'd5);
        add_query(24'd1); add_query(24'd7);
        // modulus below two
        add_reg(REG_MODULUS, 24'd0);
        add_query(24'd0);
        add_reg(REG_MODULUS, 24'd1);
        add_query(24'd5);
        // table size zero acts as one; unused index ignored
        add_setting(24'd5, 24'hFFFFFF, 24'd0);
        add_reg(REG_UNUSED, 24'h123456);
        add_query(24'd1); add_query(24'd5); add_query(24'd25);
        // oversized table size saturates, then full table size
        add_setting(24'd7, 24'd16777213, 24'hFFFFFF);
        add_query(24'(pow_mod(7, 3, 16777213)));
        add_query(24'(pow_mod(7, 4096 + 9, 16777213)));
        add_reg(REG_TSIZE, 24'd4096);
        add_query(24'(pow_mod(7, 4096 * 2 + 1, 16777213)));
        add_drain();
        // random part: small tables, mostly true powers of the base
        for (int s = 0; s < 9; s++) begin
            n = (s == 4) ? $urandom_range(2, 5) : $urandom_range(2, 6000);
            if (s == 7) n = $urandom_range(1000000, 16777215);
            b = (s == 2) ? $urandom_range(16777215) : $urandom_range(n + 20);
            m = (s == 5) ? $urandom_range(8191, 16) : $urandom_range(2, 40);
            if (s == 5) m = 8192 + $urandom_range(30, 2);
            add_setting(24'(b), 24'(n), 24'(m));
            m = (m % 8192 == 0) ? 1 : m % 8192;
            for (int q = 0; q < 11; q++) begin
                if ($urandom_range(99) < 65)
                    add_query(24'(pow_mod(b, $urandom_range(m * m), n)), s == 3);
                else
                    add_query(24'($urandom), s == 3);
                if (q == 6) add_drain();
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (job_q.size() != 0 || answer_q.size() != 0 || start || busy);
        repeat (200) @(posedge i_clk);
        if (n_errors == 0 && answer_q.size() == 0)
            $display("[discrete_log_bsgs] OK");
        else
            $display("[discrete_log_bsgs] ERROR");
        $finish;
    end

endmodule
